### design/ptqc_pkg.sv
// shared types and constants for the priority task queue with claim table
// no dependencies; imported by every module of the block
package ptqc_pkg;

    // defaults for the top level parameters
    localparam int QUEUE_DEPTH_DEF = 64;
    localparam int ITEM_SLOTS_DEF  = 256;

    // field widths
    localparam int FUNC_W    = 2;
    localparam int ITEM_W    = 8;
    localparam int PRIO_W    = 8;
    localparam int DATA_W    = 32;
    localparam int CNT_W     = 9;
    localparam int COUNT_W   = 7;

    // packed stream widths
    localparam int IN_FIELDS_W  = ITEM_W + PRIO_W + DATA_W + 1;
    localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = ITEM_W + PRIO_W + DATA_W + 2 * COUNT_W;
    localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

    // request kinds carried on tuser
    typedef enum logic [FUNC_W-1:0] {
        FUNC_PUSH     = 2'd0,
        FUNC_POP      = 2'd1,
        FUNC_COMPLETE = 2'd2,
        FUNC_FLAG     = 2'd3
    } t_func;

    // per item flags, available in bit 0
    typedef struct packed {
        logic done;
        logic claimed;
        logic avail;
    } t_flags;

    // one queued task
    typedef struct packed {
        logic [ITEM_W-1:0] item;
        logic [PRIO_W-1:0] prio;
        logic [DATA_W-1:0] data;
    } t_entry;

    // command broadcast to every queue cell
    typedef struct packed {
        logic   push;
        logic   pop;
        t_entry ent;
    } t_qcmd;

    // what a cell shows its neighbors
    typedef struct packed {
        logic   valid;
        logic   keep;
        t_entry ent;
    } t_link;

endpackage

### design/ptqc_cell.sv
// one slot of the sorted task queue; shifts toward the tail on push, head on pop
// depends on ptqc_pkg
module ptqc_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  ptqc_pkg::t_qcmd i_cmd,
    input  ptqc_pkg::t_link i_left,
    input  ptqc_pkg::t_link i_right,
    output ptqc_pkg::t_link o_link
);
    import ptqc_pkg::*;

    logic   r_valid;
    t_entry r_ent;
    logic   keep;

    // task stays put on push when it ranks at or above the new one
    assign keep = r_valid && (r_ent.prio >= i_cmd.ent.prio);

    // occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd.push) begin
            if (!keep) begin
                r_valid <= i_left.keep ? 1'b1 : i_left.valid;
            end
        end else if (i_cmd.pop) begin
            r_valid <= i_right.valid;
        end
    end

    // task contents
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            if (!keep) begin
                r_ent <= i_left.keep ? i_cmd.ent : i_left.ent;
            end
        end else if (i_cmd.pop) begin
            r_ent <= i_right.ent;
        end
    end

    assign o_link = '{valid: r_valid, keep: keep, ent: r_ent};

endmodule

### design/ptqc_flags.sv
// item flag memory with one read and one write port, cleared by a sweep after reset
// depends on ptqc_pkg
module ptqc_flags #(
    parameter int ITEM_SLOTS = ptqc_pkg::ITEM_SLOTS_DEF,
    localparam int AW = (ITEM_SLOTS > 1) ? $clog2(ITEM_SLOTS) : 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output ptqc_pkg::t_flags o_rd_data,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  ptqc_pkg::t_flags i_wr_data,
    output logic             o_ready
);
    import ptqc_pkg::*;

    t_flags        mem [ITEM_SLOTS];
    t_flags        r_rd_data;
    logic          r_clearing;
    logic [AW-1:0] r_clr_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    t_flags        wr_data;

    // clearing sweep, one entry a cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            r_clr_addr <= AW'(r_clr_addr + 1'b1);
            if (r_clr_addr == AW'(ITEM_SLOTS - 1)) begin
                r_clearing <= 1'b0;
            end
        end
    end

    // sweep owns the write port until done
    always_comb begin
        wr_en   = r_clearing ? 1'b1 : i_wr_en;
        wr_addr = r_clearing ? r_clr_addr : i_wr_addr;
        wr_data = r_clearing ? '0 : i_wr_data;
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_ready   = !r_clearing;

endmodule

### design/priority_task_queue_with_claim_core.sv
// top level: sorted task queue as a chain of cells plus item flag table and sequencer
// depends on ptqc_pkg, ptqc_cell, ptqc_flags
//
//  channel   | direction | fields (low bit up)
//  ----------+-----------+---------------------------------------------------------
//  s_axis    | in        | tuser: func; tdata: item_id, priority_req, payload,
//            |           |   avail_value
//  m_axis    | out       | tuser: ok; tdata: out_item, out_priority, out_payload,
//            |           |   dropped_count, depth
//  cfg       | in        | i_cfg_we / i_cfg_wdata: item_count
//
// the result register loads on the edge that returns the sequencer to idle.
// push, complete and flag write: accepted in idle, then finished in S_PUSH or S_WRITE.
// pop: S_POP_LOOK shifts the queue and reads the flag memory, then S_POP_CHECK tests the
//   head task; each discarded task goes back to S_POP_LOOK; an empty queue ends in S_POP_LOOK.
// after reset the flag memory sweep holds s_axis_tready low while it clears every entry.
// a stalled result holds the sequencer in its last step; a new request is taken
//   once the sequencer is back in idle, even while the result waits on m_axis.
module priority_task_queue_with_claim_core #(
    parameter int QUEUE_DEPTH = ptqc_pkg::QUEUE_DEPTH_DEF,
    parameter int ITEM_SLOTS  = ptqc_pkg::ITEM_SLOTS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [ptqc_pkg::CNT_W-1:0]        i_cfg_wdata,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // item_id[7:0], priority_req[15:8], payload[47:16], avail_value[48], zeros
    input  logic [ptqc_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // func[1:0]
    input  logic [ptqc_pkg::FUNC_W-1:0]       s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // out_item[7:0], out_priority[15:8], out_payload[47:16], dropped_count[54:48],
    // depth[61:55], zeros
    output logic [ptqc_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    // ok[0]
    output logic [0:0]                        m_axis_tuser
);
    import ptqc_pkg::*;

    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
    localparam int AW     = (ITEM_SLOTS > 1) ? $clog2(ITEM_SLOTS) : 1;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_PUSH,
        S_WRITE,
        S_POP_LOOK,
        S_POP_CHECK
    } t_state;

    t_state            r_state;
    t_state            n_state;
    t_func             r_func;
    t_entry            r_req;
    logic              r_avail;
    t_entry            r_head;
    logic [CNT_W-1:0]  r_item_count;
    logic [FILL_W-1:0] r_fill;
    logic [FILL_W-1:0] n_fill;
    logic [FILL_W-1:0] r_drop;
    logic [FILL_W-1:0] n_drop;

    logic                  r_out_valid;
    logic                  r_out_ok;
    t_entry                r_out_ent;
    logic [COUNT_W-1:0]    r_out_drop;
    logic [COUNT_W-1:0]    r_out_depth;

    t_link                 links [QUEUE_DEPTH];
    t_link                 head_link;
    t_link                 tail_link;
    t_qcmd                 cmd;
    logic [QUEUE_DEPTH-1:0] q_valid;

    logic     flags_ready;
    logic     rd_en;
    logic [AW-1:0] rd_addr;
    t_flags   rd_data;
    logic     wr_en;
    logic [AW-1:0] wr_addr;
    t_flags   wr_data;

    logic     accept;
    logic     out_free;
    t_func    in_func;
    t_entry   in_ent;
    logic     in_avail;
    logic     full;
    logic     claim;
    logic     emit;
    logic     e_ok;
    t_entry   e_ent;

    // item id lies below item_count and inside the table
    function automatic logic item_ok(input logic [ITEM_W-1:0] id,
                                     input logic [CNT_W-1:0] cnt);
        logic in_count;
        logic in_table;
        in_count = {1'b0, id} < cnt;
        in_table = (ITEM_SLOTS > 255) || (int'(id) < ITEM_SLOTS);
        return in_count && in_table;
    endfunction

    // request unpack
    assign in_func       = t_func'(s_axis_tuser);
    assign in_ent.item   = s_axis_tdata[7:0];
    assign in_ent.prio   = s_axis_tdata[15:8];
    assign in_ent.data   = s_axis_tdata[47:16];
    assign in_avail      = s_axis_tdata[48];

    assign s_axis_tready = (r_state == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_valid || m_axis_tready;
    assign full          = (r_fill == FILL_W'(QUEUE_DEPTH));

    // queue cell chain; the head sees an always-kept left neighbor
    assign head_link = '{valid: 1'b1, keep: 1'b1, ent: '0};
    assign tail_link = '{valid: 1'b0, keep: 1'b0, ent: '0};

    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        ptqc_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cmd   (cmd),
            .i_left  ((g == 0) ? head_link : links[(g == 0) ? 0 : g - 1]),
            .i_right ((g == QUEUE_DEPTH - 1) ? tail_link
                                             : links[(g == QUEUE_DEPTH - 1) ? g : g + 1]),
            .o_link  (links[g])
        );
        assign q_valid[g] = links[g].valid;
    end

    // item flag table
    ptqc_flags #(
        .ITEM_SLOTS (ITEM_SLOTS)
    ) u_flags (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .o_ready   (flags_ready)
    );

    // head task may be claimed
    assign claim = item_ok(r_head.item, r_item_count) && rd_data.avail &&
                   !rd_data.claimed && !rd_data.done;

    // sequencer next state, cell commands, flag memory accesses, result
    always_comb begin
        n_state  = r_state;
        n_fill   = r_fill;
        n_drop   = r_drop;
        cmd      = '{push: 1'b0, pop: 1'b0, ent: r_req};
        rd_en    = 1'b0;
        rd_addr  = AW'(r_req.item);
        wr_en    = 1'b0;
        wr_addr  = AW'(r_req.item);
        wr_data  = rd_data;
        emit     = 1'b0;
        e_ok     = 1'b0;
        e_ent    = '0;
        unique case (r_state)
            S_CLEAR: begin
                if (flags_ready) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                n_drop = '0;
                if (accept) begin
                    unique case (in_func) inside
                        FUNC_PUSH: n_state = S_PUSH;
                        FUNC_POP:  n_state = S_POP_LOOK;
                        FUNC_COMPLETE, FUNC_FLAG: begin
                            n_state = S_WRITE;
                            rd_en   = 1'b1;
                            rd_addr = AW'(in_ent.item);
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_PUSH: begin
                if (out_free) begin
                    emit    = 1'b1;
                    n_state = S_IDLE;
                    if (!full) begin
                        cmd.push = 1'b1;
                        n_fill   = FILL_W'(r_fill + 1'b1);
                        e_ok     = 1'b1;
                    end
                end
            end
            S_WRITE: begin
                if (out_free) begin
                    emit    = 1'b1;
                    n_state = S_IDLE;
                    if (item_ok(r_req.item, r_item_count)) begin
                        e_ok  = 1'b1;
                        wr_en = 1'b1;
                        if (r_func == FUNC_COMPLETE) begin
                            wr_data.done    = 1'b1;
                            wr_data.claimed = 1'b0;
                        end else begin
                            wr_data.avail   = r_avail;
                        end
                    end
                end
            end
            S_POP_LOOK: begin
                if (links[0].valid) begin
                    cmd.pop = 1'b1;
                    n_fill  = FILL_W'(r_fill - 1'b1);
                    rd_en   = 1'b1;
                    rd_addr = AW'(links[0].ent.item);
                    n_state = S_POP_CHECK;
                end else if (out_free) begin
                    emit    = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_POP_CHECK: begin
                if (!claim) begin
                    n_drop  = FILL_W'(r_drop + 1'b1);
                    n_state = S_POP_LOOK;
                end else if (out_free) begin
                    emit            = 1'b1;
                    e_ok            = 1'b1;
                    e_ent           = r_head;
                    wr_en           = 1'b1;
                    wr_addr         = AW'(r_head.item);
                    wr_data.claimed = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

    // state, request registers and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_fill       <= '0;
            r_drop       <= '0;
            r_item_count <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_drop  <= n_drop;
            if (i_cfg_we) begin
                r_item_count <= i_cfg_wdata;
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (accept) begin
            r_func  <= in_func;
            r_req   <= in_ent;
            r_avail <= in_avail;
        end
        if (cmd.pop) begin
            r_head <= links[0].ent;
        end
        if (emit) begin
            r_out_ok    <= e_ok;
            r_out_ent   <= e_ent;
            r_out_drop  <= (r_state == S_POP_LOOK || r_state == S_POP_CHECK)
                           ? COUNT_W'(r_drop) : '0;
            r_out_depth <= COUNT_W'(n_fill);
        end
    end

    // result pack
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_ok;
    assign m_axis_tdata  = {(OUT_DATA_W - OUT_FIELDS_W)'(0), r_out_depth, r_out_drop,
                            r_out_ent.data, r_out_ent.prio, r_out_ent.item};

    // fill counter tracks the occupied cells
    a_fill_matches_cells: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill == FILL_W'($countones(q_valid)))
        else $error("fill count differs from occupied cells");

    // occupied cells form an unbroken run from the head
    a_cells_packed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((q_valid >> 1) & ~q_valid) == '0)
        else $error("gap in the queue cell chain");

    // one request at a time
    a_one_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("request taken while another is in progress");

endmodule
